>>> rtl/plic_pkg.sv
package plic_pkg;

    localparam int NUM_SOURCES  = 64;
    localparam int NUM_CONTEXTS = 8;

    localparam int OFF_W  = 26;
    localparam int DATA_W = 32;
    localparam int SID_W  = 6;
    localparam int CFG_W  = 4;
    localparam int SRC_W  = $clog2(NUM_SOURCES);
    localparam int CTX_W  = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int CNT_W  = $clog2(NUM_CONTEXTS + 1);
    localparam int CW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic [1:0] REQ_READ   = 2'd0;
    localparam logic [1:0] REQ_WRITE  = 2'd1;
    localparam logic [1:0] REQ_INJECT = 2'd2;

    localparam logic [OFF_W-1:0] PEND_BASE  = 26'h0001000;
    localparam logic [OFF_W-1:0] EN_BASE    = 26'h0002000;
    localparam int               EN_STRIDE  = 'h80;
    localparam logic [OFF_W-1:0] CTX_BASE   = 26'h0200000;
    localparam logic [11:0]      REG_THRESH = 12'h000;
    localparam logic [11:0]      REG_CLAIM  = 12'h004;

    localparam logic [NUM_SOURCES-1:0] SRC_MASK = {{(NUM_SOURCES-1){1'b1}}, 1'b0};

    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_init;
        logic scan_step;
        logic claim;
        logic load_read;
        logic out_load;
    } plic_cmd_t;

    typedef struct packed {
        logic is_read;
        logic is_claim;
        logic scan_done;
        logic out_free;
    } plic_stat_t;

endpackage

>>> rtl/plic_ctrl.sv
module plic_ctrl
    import plic_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  plic_stat_t stat,
    output plic_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_SCAN,
        S_CLAIM,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_claim)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
                else if (stat.is_read)
                    state_next = S_READ;
                else
                    state_next = S_IDLE;
            end
            S_READ:
            begin
                cmd.load_read = 1'b1;
                state_next    = S_OUT;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_CLAIM;
            end
            S_CLAIM:
            begin
                cmd.claim  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

>>> rtl/plic_datapath.sv
module plic_datapath
    import plic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        req_type,
    input  logic [OFF_W-1:0]  bus_offset,
    input  logic [DATA_W-1:0] write_data,
    input  logic [SID_W-1:0]  source_id,
    input  logic              cfg_valid,
    input  logic [CFG_W-1:0]  cfg_data,
    input  plic_cmd_t         cmd,
    output plic_stat_t        stat,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [DATA_W-1:0] read_data
);

    typedef struct packed {
        logic             prio_hit;
        logic             pend_hit;
        logic             en_hit;
        logic [CTX_W-1:0] en_ctx;
        logic             en_word;
        logic             ctx_hit;
        logic [CTX_W-1:0] ctx_idx;
        logic             thr_hit;
        logic             claim_hit;
    } dec_t;

    logic [1:0]        type_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [DATA_W-1:0] data_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [CFG_W-1:0]  count_reg;

    logic [DATA_W-1:0] prio_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] prio_vld_reg;
    logic [DATA_W-1:0] prio_rd_reg;
    logic              prio_rd_vld_reg;
    logic [SRC_W-1:0]  rd_addr;

    logic [NUM_SOURCES-1:0] pend_reg   [NUM_CONTEXTS];
    logic [NUM_SOURCES-1:0] active_reg [NUM_CONTEXTS];
    logic [NUM_SOURCES-1:0] enable_reg [NUM_CONTEXTS];
    logic [DATA_W-1:0]      thr_reg    [NUM_CONTEXTS];

    logic [SRC_W-1:0]  scan_idx_reg;
    logic [SRC_W-1:0]  cmp_idx_reg;
    logic              cmp_vld_reg;
    logic [SRC_W-1:0]  best_reg;
    logic [DATA_W-1:0] best_prio_reg;

    logic [DATA_W-1:0] res_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_valid_reg;

    logic [CW-1:0]     ctx_n;
    dec_t              dec;
    logic [OFF_W-1:0]  en_rel;
    logic [OFF_W-1:0]  ctx_rel;
    logic [DATA_W-1:0] rd_value;
    logic [NUM_SOURCES-1:0] pend_all;
    logic [NUM_SOURCES-1:0] cand;
    logic [DATA_W-1:0] prio_q;

    // clamp the context count to 1..NUM_CONTEXTS
    always_comb
    begin
        ctx_n = CW'(count_reg);
        if (ctx_n == '0)
            ctx_n = CW'(1);
        else if (ctx_n > CW'(NUM_CONTEXTS))
            ctx_n = CW'(NUM_CONTEXTS);
    end

    always_comb
    begin
        en_rel  = off_reg - EN_BASE;
        ctx_rel = off_reg - CTX_BASE;
        dec          = '0;
        dec.prio_hit = (off_reg < OFF_W'(NUM_SOURCES * 4));
        dec.pend_hit = (off_reg >= PEND_BASE) && (off_reg < PEND_BASE + OFF_W'(8));
        dec.en_ctx   = en_rel[7 +: CTX_W];
        dec.en_word  = en_rel[2];
        dec.en_hit   = (off_reg >= EN_BASE)
                    && (off_reg < EN_BASE + OFF_W'(EN_STRIDE * NUM_CONTEXTS))
                    && (32'(en_rel[OFF_W-1:7]) < 32'(ctx_n))
                    && (en_rel[6:3] == 4'd0);
        dec.ctx_idx  = ctx_rel[12 +: CTX_W];
        dec.ctx_hit  = (off_reg >= CTX_BASE)
                    && (32'(ctx_rel[OFF_W-1:12]) < 32'(ctx_n));
        dec.thr_hit   = dec.ctx_hit && (ctx_rel[11:0] == REG_THRESH);
        dec.claim_hit = dec.ctx_hit && (ctx_rel[11:0] == REG_CLAIM);
    end

    assign stat.is_read   = (type_reg == REQ_READ);
    assign stat.is_claim  = (type_reg == REQ_READ) && dec.claim_hit;
    assign stat.scan_done = cmp_vld_reg && (cmp_idx_reg == SRC_W'(NUM_SOURCES - 1));
    assign stat.out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        pend_all = '0;
        for (int i = 0; i < NUM_CONTEXTS; i++)
        begin
            if (CW'(i) < ctx_n)
                pend_all = pend_all | pend_reg[i];
        end
    end

    assign prio_q = prio_rd_vld_reg ? prio_rd_reg : '0;
    assign cand   = pend_reg[dec.ctx_idx] & enable_reg[dec.ctx_idx]
                  & ~active_reg[dec.ctx_idx] & SRC_MASK;

    always_comb
    begin
        logic [63:0] wide;
        wide     = '0;
        rd_value = '0;
        if (dec.prio_hit)
            rd_value = prio_q;
        else if (dec.pend_hit)
        begin
            wide     = 64'(pend_all);
            rd_value = off_reg[2] ? wide[63:32] : wide[31:0];
        end
        else if (dec.en_hit)
        begin
            wide     = 64'(enable_reg[dec.en_ctx]);
            rd_value = dec.en_word ? wide[63:32] : wide[31:0];
        end
        else if (dec.thr_hit)
            rd_value = thr_reg[dec.ctx_idx];
    end

    assign rd_addr = cmd.scan_step ? scan_idx_reg : off_reg[2 +: SRC_W];

    // capture the request and the configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= CFG_W'(1);
        else if (cfg_valid)
            count_reg <= cfg_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req_type;
            off_reg  <= bus_offset;
            data_reg <= write_data;
            sid_reg  <= source_id;
        end
    end

    // priority store
    always_ff @(posedge clk)
    begin
        if (cmd.exec && (type_reg == REQ_WRITE) && dec.prio_hit)
            prio_mem[off_reg[2 +: SRC_W]] <= data_reg;
        prio_rd_reg <= prio_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_vld_reg    <= '0;
            prio_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec && (type_reg == REQ_WRITE) && dec.prio_hit)
                prio_vld_reg[off_reg[2 +: SRC_W]] <= (off_reg[2 +: SRC_W] != '0);
            prio_rd_vld_reg <= prio_vld_reg[rd_addr];
        end
    end

    // per-context state
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [63:0] wide;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                pend_reg[i]   <= '0;
                active_reg[i] <= '0;
                enable_reg[i] <= '0;
                thr_reg[i]    <= '0;
            end
        end
        else
        begin
            wide = 64'(enable_reg[dec.en_ctx]);
            if (dec.en_word)
                wide[63:32] = data_reg;
            else
                wide[31:0] = data_reg;
            if (cmd.exec && (type_reg == REQ_WRITE))
            begin
                if (dec.en_hit)
                    enable_reg[dec.en_ctx] <= NUM_SOURCES'(wide) & SRC_MASK;
                if (dec.thr_hit)
                    thr_reg[dec.ctx_idx] <= data_reg;
                if (dec.claim_hit && (data_reg != '0)
                    && (data_reg < DATA_W'(NUM_SOURCES)))
                    active_reg[dec.ctx_idx][data_reg[SRC_W-1:0]] <= 1'b0;
            end
            if (cmd.exec && (type_reg == REQ_INJECT) && (sid_reg != '0)
                && ({1'b0, sid_reg} < (SID_W + 1)'(NUM_SOURCES)))
            begin
                for (int i = 0; i < NUM_CONTEXTS; i++)
                begin
                    if (CW'(i) < ctx_n)
                        pend_reg[i][sid_reg[SRC_W-1:0]] <= 1'b1;
                end
            end
            // move the winner from pending to active
            if (cmd.claim && (best_reg != '0))
            begin
                pend_reg[dec.ctx_idx][best_reg]   <= 1'b0;
                active_reg[dec.ctx_idx][best_reg] <= 1'b1;
            end
        end
    end

    // claim scan: one source per cycle, the compare follows in the cycle after the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_vld_reg <= 1'b0;
        else if (cmd.scan_init)
            cmp_vld_reg <= 1'b0;
        else if (cmd.scan_step)
            cmp_vld_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            scan_idx_reg  <= SRC_W'(1);
            cmp_idx_reg   <= SRC_W'(1);
            best_reg      <= '0;
            best_prio_reg <= thr_reg[dec.ctx_idx];
        end
        else if (cmd.scan_step)
        begin
            if (scan_idx_reg != SRC_W'(NUM_SOURCES - 1))
                scan_idx_reg <= scan_idx_reg + SRC_W'(1);
            cmp_idx_reg <= scan_idx_reg;
            if (cmp_vld_reg && cand[cmp_idx_reg] && (prio_q > best_prio_reg))
            begin
                best_reg      <= cmp_idx_reg;
                best_prio_reg <= prio_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_read)
            res_reg <= rd_value;
        else if (cmd.claim)
            res_reg <= DATA_W'(best_reg);
        if (cmd.out_load)
            out_data_reg <= res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

endmodule

>>> rtl/plic_interrupt_controller.sv
// Interrupt controller with per-source priority and per-context claim/complete.
// Request channel: in_valid/in_stall with req_type, bus_offset, write_data,
// source_id. A request is taken when in_valid is high and in_stall is low.
// Response channel: out_valid/out_stall with read_data; only reads respond.
// Configuration: cfg_valid/cfg_ready with cfg_data, the number of contexts
// in use; cfg_ready is always high, write it only while the block is idle.
// Flow: one request at a time. A write or an inject is captured and executed.
// A plain read is captured, executed, loaded into the result register and then
// into the output register. A claim read scans the priority RAM one source per
// cycle through its single read port.
// A finished response waits in the output register while the next request
// is taken; if the receiver stalls, the following read holds until the
// register frees up, and in_stall stays high meanwhile.
// Reset clears all priorities, pending, active, enable and threshold state
// at once and sets the context count to 1.
module plic_interrupt_controller
    import plic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [OFF_W-1:0]  bus_offset,
    input  logic [DATA_W-1:0] write_data,
    input  logic [SID_W-1:0]  source_id,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] read_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data
);

    plic_cmd_t  cmd;
    plic_stat_t stat;

    assign cfg_ready = 1'b1;

    plic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    plic_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_type   (req_type),
        .bus_offset (bus_offset),
        .write_data (write_data),
        .source_id  (source_id),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .stat       (stat),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .read_data  (read_data)
    );

endmodule

>>> rtl/plic_checker.sv
module plic_sva_checker
    import plic_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] read_data,
    input logic              cfg_valid,
    input logic              cfg_ready
);

    // a stalled response holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(read_data))
        else $error("stalled response changed");

    // one request at a time: busy right after taking one
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken while busy");

    // a response is only launched while a request is in progress
    a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("response without a request in progress");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind plic_interrupt_controller plic_sva_checker u_plic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

>>> sim/plic_checker.sv
module plic_checker
    import plic_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [1:0]        req_type,
    input  logic [OFF_W-1:0]  bus_offset,
    input  logic [DATA_W-1:0] write_data,
    input  logic [SID_W-1:0]  source_id,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [DATA_W-1:0] read_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                fail_count,
    output int                reads_pending,
    output int                claims_seen
);

    logic [31:0] prio_m [NUM_SOURCES];
    logic [63:0] pend_m [NUM_CONTEXTS];
    logic [63:0] act_m  [NUM_CONTEXTS];
    logic [63:0] en_m   [NUM_CONTEXTS];
    logic [31:0] thr_m  [NUM_CONTEXTS];
    logic [3:0]  ctx_cnt_m;
    logic [31:0] read_data_q [$];

    function automatic int ctx_used();
        int n;
        n = ctx_cnt_m;
        if (n < 1) n = 1;
        if (n > NUM_CONTEXTS) n = NUM_CONTEXTS;
        return n;
    endfunction

    function automatic logic [31:0] best_claim(int c);
        logic [63:0] cand;
        logic [31:0] bp;
        logic [31:0] b;
        cand = pend_m[c] & en_m[c] & ~act_m[c] & 64'(SRC_MASK);
        bp = thr_m[c];
        b = 0;
        for (int s = 1; s < NUM_SOURCES; s++)
            if (cand[s] && prio_m[s] > bp)
            begin
                b = s;
                bp = prio_m[s];
            end
        return b;
    endfunction

    task automatic apply_request(logic [1:0] t, logic [31:0] off, logic [31:0] d,
                                 logic [5:0] sid);
        int n, c, w;
        logic [31:0] r, v;
        logic [63:0] all;
        n = ctx_used();
        r = 0;
        if (t == REQ_READ)
        begin
            if (off < NUM_SOURCES * 4)
                r = prio_m[off / 4];
            else if (off >= PEND_BASE && off < PEND_BASE + 8)
            begin
                all = 0;
                for (int i = 0; i < n; i++) all |= pend_m[i];
                r = ((off - PEND_BASE) / 4 == 0) ? all[31:0] : all[63:32];
            end
            else if (off >= EN_BASE && off < EN_BASE + EN_STRIDE * NUM_CONTEXTS)
            begin
                c = (off - EN_BASE) / EN_STRIDE;
                w = ((off - EN_BASE) % EN_STRIDE) / 4;
                if (c < n && w < 2) r = (w == 0) ? en_m[c][31:0] : en_m[c][63:32];
            end
            else if (off >= CTX_BASE)
            begin
                c = (off - CTX_BASE) / 'h1000;
                w = (off - CTX_BASE) % 'h1000;
                if (c < n)
                begin
                    if (w == REG_THRESH) r = thr_m[c];
                    else if (w == REG_CLAIM)
                    begin
                        r = best_claim(c);
                        if (r != 0)
                        begin
                            pend_m[c][r] = 1'b0;
                            act_m[c][r] = 1'b1;
                            claims_seen++;
                        end
                    end
                end
            end
            read_data_q.push_back(r);
        end
        else if (t == REQ_WRITE)
        begin
            if (off < NUM_SOURCES * 4)
            begin
                if (off / 4 > 0) prio_m[off / 4] = d;
            end
            else if (off >= EN_BASE && off < EN_BASE + EN_STRIDE * NUM_CONTEXTS)
            begin
                c = (off - EN_BASE) / EN_STRIDE;
                w = ((off - EN_BASE) % EN_STRIDE) / 4;
                if (c < n && w < 2)
                begin
                    if (w == 0) en_m[c][31:0] = d;
                    else en_m[c][63:32] = d;
                    en_m[c] &= 64'(SRC_MASK);
                end
            end
            else if (off >= CTX_BASE)
            begin
                c = (off - CTX_BASE) / 'h1000;
                w = (off - CTX_BASE) % 'h1000;
                if (c < n)
                begin
                    if (w == REG_THRESH) thr_m[c] = d;
                    else if (w == REG_CLAIM && d > 0 && d < NUM_SOURCES)
                        act_m[c][d] = 1'b0;
                end
            end
        end
        else if (t == REQ_INJECT)
        begin
            if (sid != 0 && sid < NUM_SOURCES)
                for (int i = 0; i < n; i++) pend_m[i][sid] = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SOURCES; i++) prio_m[i] = 0;
            for (int i = 0; i < NUM_CONTEXTS; i++)
            begin
                pend_m[i] = 0;
                act_m[i] = 0;
                en_m[i] = 0;
                thr_m[i] = 0;
            end
            ctx_cnt_m = 4'd1;
            fail_count <= 0;
            claims_seen = 0;
            read_data_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (read_data_q.size() == 0)
                begin
                    $error("unexpected response read_data=%h", read_data);
                    fail_count <= fail_count + 1;
                end
                else if (read_data !== read_data_q[0])
                begin
                    $error("read_data mismatch: expected %h, actual %h",
                           read_data_q[0], read_data);
                    fail_count <= fail_count + 1;
                    void'(read_data_q.pop_front());
                end
                else
                    void'(read_data_q.pop_front());
            end
            if (in_valid && !in_stall)
                apply_request(req_type, 32'(bus_offset), write_data, source_id);
            if (cfg_valid && cfg_ready) ctx_cnt_m = cfg_data;
        end
    end

    assign reads_pending = read_data_q.size();

endmodule

>>> sim/tb_plic_interrupt_controller.sv
module tb_plic_interrupt_controller;
    import plic_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [1:0]        req_type;
    logic [OFF_W-1:0]  bus_offset;
    logic [DATA_W-1:0] write_data;
    logic [SID_W-1:0]  source_id;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] read_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_count;
    int                reads_pending;
    int                claims_seen;
    int                request_total;
    logic              stall_on;

    plic_interrupt_controller u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .bus_offset(bus_offset), .write_data(write_data),
        .source_id(source_id), .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    plic_checker u_check (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .bus_offset(bus_offset), .write_data(write_data),
        .source_id(source_id), .out_valid(out_valid), .out_stall(out_stall),
        .read_data(read_data), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_data(cfg_data), .fail_count(fail_count),
        .reads_pending(reads_pending), .claims_seen(claims_seen)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // receiver stalls in bursts, with quiet stretches between; no stalls while stall_on is low
    initial
    begin
        int n;
        out_stall = 0;
        stall_on = 1;
        forever
        begin
            n = gap_len();
            repeat (n) @(posedge clk) out_stall <= stall_on;
            @(posedge clk) out_stall <= 1'b0;
            n = $urandom_range(0, 6);
            repeat (n) @(posedge clk);
        end
    end

    // valid stays high after acceptance until the next request or a gap drops it
    task automatic send_request(logic [1:0] t, logic [OFF_W-1:0] off, logic [31:0] d,
                                logic [5:0] sid);
        int g;
        g = gap_len();
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= t;
        bus_offset <= off;
        write_data <= d;
        source_id <= sid;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        request_total++;
    endtask

    task automatic drain_and_config(logic [3:0] v);
        in_valid <= 1'b0;
        repeat (NUM_SOURCES + 10) @(posedge clk);
        while (reads_pending != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [OFF_W-1:0] pick_offset(int nctx);
        int c;
        c = $urandom_range(0, nctx);
        case ($urandom_range(0, 9))
            0, 1: return OFF_W'($urandom_range(0, NUM_SOURCES - 1) * 4);
            2: return PEND_BASE + OFF_W'($urandom_range(0, 1) * 4);
            3, 4: return EN_BASE + OFF_W'(c * EN_STRIDE + $urandom_range(0, 2) * 4);
            5: return CTX_BASE + OFF_W'(c * 'h1000);
            6, 7, 8: return CTX_BASE + OFF_W'(c * 'h1000) + OFF_W'(REG_CLAIM);
            default: return OFF_W'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] pick_data(logic [OFF_W-1:0] off);
        if (off >= CTX_BASE && off[11:0] == REG_CLAIM && $urandom_range(0, 4) != 0)
            return $urandom_range(0, NUM_SOURCES);
        if (off < NUM_SOURCES * 4 || (off >= CTX_BASE && off[11:0] == REG_THRESH))
            return ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, 7);
        return $urandom();
    endfunction

    initial
    begin
        logic [3:0] settings [6];
        logic [OFF_W-1:0] off;
        int nctx;
        int r;
        settings = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
        rst_n = 0;
        in_valid = 0;
        req_type = 0;
        bus_offset = 0;
        write_data = 0;
        source_id = 0;
        cfg_valid = 0;
        cfg_data = 0;
        request_total = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges of each field, a claim round trip, each odd case
        send_request(REQ_WRITE, 26'h4, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_WRITE, 26'hFC, 32'd3, 6'd0);
        send_request(REQ_WRITE, 26'h0, 32'd9, 6'd0);
        send_request(REQ_READ, 26'h0, 32'd0, 6'd0);
        send_request(REQ_WRITE, EN_BASE, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_WRITE, EN_BASE + 26'h4, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_WRITE, EN_BASE + 26'h8, 32'h1234, 6'd0);
        send_request(REQ_READ, EN_BASE, 32'd0, 6'd0);
        send_request(REQ_INJECT, 26'h0, 32'd0, 6'd0);
        send_request(REQ_INJECT, 26'h0, 32'd0, 6'd63);
        send_request(REQ_INJECT, 26'h0, 32'd0, 6'd1);
        send_request(REQ_READ, PEND_BASE, 32'd0, 6'd0);
        send_request(REQ_READ, PEND_BASE + 26'h4, 32'd0, 6'd0);
        send_request(REQ_READ, CTX_BASE + 26'(REG_CLAIM), 32'd0, 6'd0);
        send_request(REQ_READ, CTX_BASE + 26'(REG_CLAIM), 32'd0, 6'd0);
        send_request(REQ_READ, CTX_BASE + 26'(REG_CLAIM), 32'd0, 6'd0);
        send_request(REQ_WRITE, CTX_BASE + 26'(REG_CLAIM), 32'd0, 6'd0);
        send_request(REQ_WRITE, CTX_BASE + 26'(REG_CLAIM), 32'd64, 6'd0);
        send_request(REQ_WRITE, CTX_BASE + 26'(REG_CLAIM), 32'd1, 6'd0);
        send_request(REQ_WRITE, CTX_BASE, 32'hFFFF_FFFF, 6'd0);
        send_request(REQ_READ, CTX_BASE, 32'd0, 6'd0);
        send_request(REQ_READ, CTX_BASE + 26'h1000, 32'd0, 6'd0);
        send_request(2'd3, 26'h3FF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_request(REQ_READ, 26'h3FF_FFFF, 32'd0, 6'd0);
        send_request(REQ_WRITE, CTX_BASE, 32'd0, 6'd0);

        for (int p = 0; p < 6; p++)
        begin
            drain_and_config(settings[p]);
            nctx = (settings[p] < 1) ? 1 : (settings[p] > NUM_CONTEXTS) ? NUM_CONTEXTS
                   : settings[p];
            stall_on = (p != 2);
            for (int i = 0; i < 290; i++)
            begin
                r = $urandom_range(0, 19);
                off = pick_offset(nctx);
                if (r < 6)
                    send_request(REQ_INJECT, OFF_W'($urandom()), $urandom(),
                                 SID_W'($urandom()));
                else if (r < 12)
                    send_request(REQ_WRITE, off, pick_data(off), SID_W'($urandom()));
                else if (r < 19)
                    send_request(REQ_READ, off, $urandom(), SID_W'($urandom()));
                else
                    send_request(2'd3, off, $urandom(), SID_W'($urandom()));
            end
        end

        in_valid <= 1'b0;
        repeat (NUM_SOURCES + 10) @(posedge clk);
        while (reads_pending != 0) @(posedge clk);
        $display("Covered %0d requests over six context counts, %0d sources claimed.",
                 request_total, claims_seen);
        if (fail_count == 0)
            $display("tb_plic_interrupt_controller: done, clean");
        else
            $display("tb_plic_interrupt_controller: done, errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("tb_plic_interrupt_controller: done, errors");
        $finish;
    end

endmodule
